// ===== rtl/core/pba_pkg.sv =====
// Shared types and constants of the paged bump allocator.
package pba_pkg;

  // Default number of page slots.
  localparam int NUM_PAGES_DEF = 16;

  // Field and register widths.
  localparam int SIZE_W   = 16;
  localparam int HDR_W    = 8;
  localparam int PAGE_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_IDX_W = 4;
  localparam int ERR_W    = 2;

  // Register reset values.
  localparam logic [PAGE_W-1:0] PAGE_BYTES_RESET   = 16'd4096;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RESET = 8'd24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'd1;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SIZE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_SLOT = 2'd2;

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // One result beat.
  typedef struct packed {
    logic                 granted;
    logic [OUT_IDX_W-1:0] page_index;
    logic [SIZE_W-1:0]    byte_offset;
    logic                 opened_page;
    logic [ERR_W-1:0]     error_code;
  } res_t;

endpackage

// ===== rtl/core/pba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pba_engine.sv =====
// Request sequencer: page scan from newest to oldest, fit test and write-back.
module pba_engine #(
  parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF,
  parameter int PIDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
  parameter int CNT_W = $clog2(NUM_PAGES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pba_pkg::SIZE_W-1:0] alloc_size,
  input  logic [pba_pkg::PAGE_W-1:0] page_bytes,
  input  logic [pba_pkg::HDR_W-1:0]  header_bytes,
  output logic                       busy,
  output logic                       ram_we,
  output logic [PIDX_W-1:0]          ram_waddr,
  output logic [pba_pkg::SIZE_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [PIDX_W-1:0]          ram_raddr,
  input  logic [pba_pkg::SIZE_W-1:0] ram_rdata,
  output logic                       res_valid,
  output pba_pkg::res_t              res
);

  pba_pkg::state_t state_r, state_nxt;

  logic [pba_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [PIDX_W-1:0]          addr_r, addr_nxt;
  logic [PIDX_W-1:0]          addr_q_r, addr_q_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic                       issue_done_r, issue_done_nxt;
  logic [CNT_W-1:0]           open_r, open_nxt;
  logic                       page0_wr_r, page0_wr_nxt;

  logic                       accept;
  logic [pba_pkg::PAGE_W-1:0] hdr_ext;
  logic [pba_pkg::PAGE_W-1:0] usable;
  logic                       oversize;
  logic [pba_pkg::SIZE_W-1:0] used_eff;
  logic [pba_pkg::SIZE_W:0]   start_sum;
  logic [pba_pkg::SIZE_W+1:0] end_sum;
  logic [pba_pkg::SIZE_W:0]   grow_sum;
  logic                       fit;
  logic                       last;
  logic                       can_open;
  logic                       do_open;
  logic [CNT_W-1:0]           newest;
  logic [PIDX_W-1:0]          sel_idx;
  logic [PIDX_W+3:0]          idx_pad;

  // Request acceptance and the oversize check against the usable page room.
  assign accept   = start && (state_r == pba_pkg::ST_IDLE);
  assign hdr_ext  = {{(pba_pkg::PAGE_W-pba_pkg::HDR_W){1'b0}}, header_bytes};
  assign usable   = (hdr_ext < page_bytes) ? (page_bytes - hdr_ext) : '0;
  assign oversize = alloc_size > usable;

  // Page 0 starts open without ever being written, so it reads as empty.
  assign used_eff = ((addr_q_r == '0) && !page0_wr_r) ? '0 : ram_rdata;

  // Fit test on the page whose record just came back from the RAM.
  assign start_sum = {{(pba_pkg::SIZE_W+1-pba_pkg::HDR_W){1'b0}}, header_bytes}
                   + {1'b0, used_eff};
  assign end_sum   = {1'b0, start_sum} + {2'b00, size_r};
  assign grow_sum  = {1'b0, used_eff} + {1'b0, size_r};
  assign fit       = (state_r == pba_pkg::ST_SCAN) && rd_vld_r
                   && (end_sum <= {2'b00, page_bytes});
  assign last      = (state_r == pba_pkg::ST_SCAN) && rd_vld_r && (addr_q_r == '0);
  assign can_open  = open_r < CNT_W'(NUM_PAGES);
  assign do_open   = last && !fit && can_open;
  assign newest    = open_r - CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pba_pkg::ST_IDLE: begin
        if (accept && !oversize) begin
          state_nxt = pba_pkg::ST_SCAN;
        end
      end
      pba_pkg::ST_SCAN: begin
        if (fit || last) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pba_pkg::ST_IDLE;
    endcase
  end

  // Outputs: RAM accesses and the result beat.
  always_comb begin
    busy      = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      pba_pkg::ST_IDLE: begin
        res_valid = accept && oversize;
      end
      pba_pkg::ST_SCAN: begin
        busy      = 1'b1;
        ram_re    = !issue_done_r;
        ram_we    = fit || do_open;
        res_valid = fit || last;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign ram_raddr = addr_r;
  assign sel_idx   = fit ? addr_q_r : open_r[PIDX_W-1:0];
  assign ram_waddr = sel_idx;
  assign ram_wdata = fit ? grow_sum[pba_pkg::SIZE_W-1:0] : size_r;
  assign idx_pad   = {4'b0000, sel_idx};

  // Result fields; every error beat carries zeros besides its code.
  always_comb begin
    res = '0;
    if (state_r == pba_pkg::ST_IDLE) begin
      res.error_code = pba_pkg::ERR_SIZE;
    end else if (fit) begin
      res.granted     = 1'b1;
      res.page_index  = idx_pad[pba_pkg::OUT_IDX_W-1:0];
      res.byte_offset = start_sum[pba_pkg::SIZE_W-1:0];
      res.error_code  = pba_pkg::ERR_OK;
    end else if (can_open) begin
      res.granted     = 1'b1;
      res.page_index  = idx_pad[pba_pkg::OUT_IDX_W-1:0];
      res.byte_offset = hdr_ext;
      res.opened_page = 1'b1;
      res.error_code  = pba_pkg::ERR_OK;
    end else begin
      res.error_code = pba_pkg::ERR_NO_SLOT;
    end
  end

  // Scan pointer, read pipeline tracking and page bookkeeping.
  always_comb begin
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    addr_q_nxt     = addr_q_r;
    rd_vld_nxt     = rd_vld_r;
    issue_done_nxt = issue_done_r;
    open_nxt       = open_r;
    page0_wr_nxt   = page0_wr_r;
    if (accept) begin
      size_nxt       = alloc_size;
      addr_nxt       = newest[PIDX_W-1:0];
      rd_vld_nxt     = 1'b0;
      issue_done_nxt = 1'b0;
    end else if (state_r == pba_pkg::ST_SCAN) begin
      rd_vld_nxt = !issue_done_r;
      addr_q_nxt = addr_r;
      if (!issue_done_r) begin
        if (addr_r == '0) begin
          issue_done_nxt = 1'b1;
        end else begin
          addr_nxt = addr_r - PIDX_W'(1);
        end
      end
    end
    if (do_open) begin
      open_nxt = open_r + CNT_W'(1);
    end
    if (ram_we && (ram_waddr == '0)) begin
      page0_wr_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pba_pkg::ST_IDLE;
      rd_vld_r     <= 1'b0;
      issue_done_r <= 1'b0;
      open_r       <= CNT_W'(1);
      page0_wr_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      issue_done_r <= issue_done_nxt;
      open_r       <= open_nxt;
      page0_wr_r   <= page0_wr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    addr_r   <= addr_nxt;
    addr_q_r <= addr_q_nxt;
  end

endmodule

// ===== rtl/core/paged_bump_allocator_top.sv =====
// Top level of the paged bump allocator: configuration registers, page RAM, result beat.
//
// A request is taken when start is high and busy is low. A request larger than the
// usable page room is answered in the next cycle with busy staying low. Any other
// request holds busy while the open pages are scanned from the newest page back to
// the one that fits, or down to page 0 when none does (1 to NUM_PAGES pages), and
// its result beat appears in the first cycle in which busy is low again. The rate
// is set by the single read port of the used-bytes RAM, which returns one page
// record per cycle. Every result is shown for exactly one cycle with out_strobe high
// and cannot be held off, so the receiver must take it then.
// Configuration writes belong in idle periods; the RAM needs no clearing pass after
// reset.
module paged_bump_allocator_top #(
  parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pba_pkg::SIZE_W-1:0]    in_alloc_size,
  output logic                          out_strobe,
  output logic                          out_granted,
  output logic [pba_pkg::OUT_IDX_W-1:0] out_page_index,
  output logic [pba_pkg::SIZE_W-1:0]    out_byte_offset,
  output logic                          out_opened_page,
  output logic [pba_pkg::ERR_W-1:0]     out_error_code,
  input  logic                          cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int PIDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W  = $clog2(NUM_PAGES + 1);

  logic [pba_pkg::PAGE_W-1:0] page_bytes_r, page_bytes_nxt;
  logic [pba_pkg::HDR_W-1:0]  header_bytes_r, header_bytes_nxt;
  logic                       out_strobe_r;
  pba_pkg::res_t              out_res_r;

  logic                       ram_we;
  logic [PIDX_W-1:0]          ram_waddr;
  logic [pba_pkg::SIZE_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [PIDX_W-1:0]          ram_raddr;
  logic [pba_pkg::SIZE_W-1:0] ram_rdata;
  logic                       res_valid;
  pba_pkg::res_t              res;

  // Configuration register writes.
  always_comb begin
    page_bytes_nxt   = page_bytes_r;
    header_bytes_nxt = header_bytes_r;
    if (cfg_we) begin
      case (cfg_index)
        pba_pkg::CFG_PAGE_BYTES:   page_bytes_nxt   = cfg_wdata[pba_pkg::PAGE_W-1:0];
        pba_pkg::CFG_HEADER_BYTES: header_bytes_nxt = cfg_wdata[pba_pkg::HDR_W-1:0];
        default: begin
          page_bytes_nxt = page_bytes_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r   <= pba_pkg::PAGE_BYTES_RESET;
      header_bytes_r <= pba_pkg::HEADER_BYTES_RESET;
      out_strobe_r   <= 1'b0;
    end else begin
      page_bytes_r   <= page_bytes_nxt;
      header_bytes_r <= header_bytes_nxt;
      out_strobe_r   <= res_valid;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  // Used-bytes record of every page slot.
  pba_ram #(
    .WIDTH (pba_pkg::SIZE_W),
    .DEPTH (NUM_PAGES),
    .ADDR_W(PIDX_W)
  ) u_used_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Scan sequencer.
  pba_engine #(
    .NUM_PAGES(NUM_PAGES),
    .PIDX_W   (PIDX_W),
    .CNT_W    (CNT_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .alloc_size  (in_alloc_size),
    .page_bytes  (page_bytes_r),
    .header_bytes(header_bytes_r),
    .busy        (busy),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_strobe      = out_strobe_r;
  assign out_granted     = out_res_r.granted;
  assign out_page_index  = out_res_r.page_index;
  assign out_byte_offset = out_res_r.byte_offset;
  assign out_opened_page = out_res_r.opened_page;
  assign out_error_code  = out_res_r.error_code;

`ifndef NO_ASSERTIONS
  // A beat is a grant exactly when it carries no error code.
  a_grant_vs_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_granted == (out_error_code == pba_pkg::ERR_OK)))
    else $error("grant flag disagrees with error code");

  // Opening a page always grants the request at the header offset.
  a_open_grants: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_opened_page) |-> (out_granted
      && (out_byte_offset == {{(pba_pkg::SIZE_W-pba_pkg::HDR_W){1'b0}}, header_bytes_r})))
    else $error("opened page beat is not a grant at the header offset");

  // An accepted request is either answered at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted request was dropped");

  // No new result beat appears while a scan is still in progress.
  a_no_beat_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy) && $past(rst_n)) |-> !out_strobe)
    else $error("result beat in the middle of a scan");
`endif

endmodule
